// ===== hw/rtl/plob_pkg.sv =====
// Shared types, codes and default sizes of the price level order book.
package plob_pkg;

  localparam int SLOTS_DEF      = 256;
  localparam int CHAIN_DEF      = 256;
  localparam int PRICE_BITS_DEF = 32;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOT_TICKS = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_READ_LIMIT = 1'b1;
  localparam logic [CFG_DATA_BITS-1:0]  RESET_TICKS    = 5'd10;

  localparam logic signed [31:0] MARK_SIZE = -32'sd1;

  localparam logic [1:0] MODE_NEW    = 2'd0;
  localparam logic [1:0] MODE_CHANGE = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic               side;
    logic [31:0]        price;
    logic signed [31:0] size_delta;
    logic               read_request;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        level_price;
    logic signed [31:0] level_size;
    logic               end_of_side;
    logic               last;
  } level_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CHECK, ST_DIST_GO, ST_DIST_WAIT, ST_REBASE,
    ST_CLR, ST_CLR_CHK, ST_FREE, ST_FREE_RD, ST_N_HEAD_RQ, ST_N_HEAD, ST_N_WALK,
    ST_N_WALK_RD, ST_TAKE, ST_TAKE_RD, ST_PLACE_A, ST_PLACE_B, ST_C_WALK, ST_C_RD,
    ST_C_FOUND, ST_C_PULL, ST_RS, ST_RS_RD, ST_DONE, ST_RD_SIDE, ST_RD_SLOT,
    ST_RD_DATA, ST_RD_MARK
  } state_t;

endpackage

// ===== hw/rtl/plob_ram.sv =====
// Generic single write port RAM with one registered read port.
module plob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/plob_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module plob_div #(
  parameter int DW = 32,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          run;
  logic [VW:0]   trial;
  logic          ge;
  logic [VW:0]   diff;

  assign trial = {rem, quo[DW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = ge ? trial - {1'b0, dvs} : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= CW'(DW);
        run <= 1'b1;
      end else if (run) begin
        quo <= {quo[DW-2:0], ge};
        rem <= diff[VW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/price_level_order_book.sv =====
// Price level order book: one sequencer over a block RAM and a hole queue RAM.
// An update walks the chain blocks of its slot; a ring distance costs one pass of the shared
// divider, a rebase one more pass besides clearing the slots it passes and freeing their
// chain blocks. A best level rescan steps through the slots of the side in turn.
// A snapshot reads both sides in turn, each ending with a mark. Items are taken
// one at a time while busy is low; results come one per strobe and are never stalled.
// After reset the 2*SLOTS_PER_SIDE slot heads are cleared, one a cycle, with busy high.
module price_level_order_book #(
  parameter int SLOTS_PER_SIDE = plob_pkg::SLOTS_DEF,
  parameter int CHAIN_BLOCKS   = plob_pkg::CHAIN_DEF,
  parameter int PRICE_BITS     = plob_pkg::PRICE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  plob_pkg::cmd_t                      cmd,
  output logic                                result_valid,
  output plob_pkg::level_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plob_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [plob_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import plob_pkg::*;

  localparam int S     = SLOTS_PER_SIDE;
  localparam int C     = CHAIN_BLOCKS;
  localparam int PB    = PRICE_BITS;
  localparam int TOTAL = 2 * S + C;
  localparam int IDXW  = $clog2(TOTAL + 1);
  localparam int AW    = $clog2(TOTAL);
  localparam int SW    = $clog2(S);
  localparam int NW    = $clog2(S + 1);
  localparam int HW    = $clog2(C);
  localparam int HCW   = $clog2(C + 1);
  localparam int VW    = ($clog2(S + 1) > 5) ? $clog2(S + 1) : 5;
  localparam int WW    = PB + 32 + IDXW;
  localparam int CMPW  = (PB > 13) ? PB + 1 : 14;
  localparam bit S_POW2 = (S == (1 << SW));
  localparam logic [IDXW-1:0] NIL = IDXW'(TOTAL);

  function automatic logic [IDXW-1:0] head_of(input logic sd, input logic [SW-1:0] sl);
    head_of = sd ? IDXW'(S) + IDXW'(sl) : IDXW'(sl);
  endfunction

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] sl);
    slot_inc = (sl == SW'(S - 1)) ? '0 : sl + 1'b1;
  endfunction

  // True when price a is worse than price b on the given side.
  function automatic logic worse(input logic [PB-1:0] a, input logic [PB-1:0] b,
                                 input logic bid);
    worse = bid ? (a < b) : (a > b);
  endfunction

  function automatic logic [WW-1:0] pack(input logic [PB-1:0] p, input logic [31:0] sz,
                                         input logic [IDXW-1:0] nx);
    pack = {p, sz, nx};
  endfunction

  state_t state, state_next;

  logic [IDXW-1:0] init_cnt;
  logic [4:0]      slot_ticks, read_limit;
  logic [4:0]      tick;

  logic [1:0]      c_mode;
  logic            c_side, c_rr;
  logic [PB-1:0]   c_price;
  logic [31:0]     c_delta;

  logic [PB-1:0]   best_price [2];
  logic [SW-1:0]   best_slot [2];

  logic [HW-1:0]   hole_head;
  logic [HCW-1:0]  hole_count;
  logic [IDXW-1:0] bump;

  logic            neg, rebased, front;
  logic [PB-1:0]   mag, off;
  logic [VW-1:0]   tick_rem;
  logic [SW-1:0]   ring;
  logic [IDXW-1:0] head, cur, last, nb, link;
  logic [PB-1:0]   lw_price;
  logic [31:0]     lw_size, cw_size;
  logic [IDXW-1:0] lw_next, cw_next;
  logic [4:0]      walk_i;
  logic [NW-1:0]   clr_left;
  logic [SW-1:0]   clr_slot;
  logic [NW-1:0]   rs_k;
  logic [SW-1:0]   rs_slot;
  logic [PB-1:0]   rs_step;
  logic            rd_side, rd_at_head;
  logic [4:0]      rd_cnt, rd_j;
  logic [NW-1:0]   rd_i;
  logic [SW-1:0]   rd_slot;

  logic            mem_we;
  logic [IDXW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0]   mem_wdata, mem_rdata;
  logic [PB-1:0]   rd_price;
  logic [31:0]     rd_size;
  logic [IDXW-1:0] rd_next;

  logic            give_en, give_to_bump, hole_push;
  logic [IDXW-1:0] give_idx;
  logic [HCW:0]    tail_sum;
  logic [HW-1:0]   hole_tail, hole_inc;
  logic [IDXW-1:0] hole_rdata;

  logic            div_start, div_done;
  logic [PB-1:0]   div_a, div_quo;
  logic [VW-1:0]   div_b, div_rem;

  logic            emit;
  level_t          emit_word;

  logic            cmd_ok;
  logic [PB-1:0]   bp, dist_hi, dist_lo, m_comb, off_comb, step_comb;
  logic            neg_comb, rebase_go, off_big;
  logic [SW:0]     ring_sum, nb_sum;
  logic [SW-1:0]   ring_comb, offmod, nb_slot;
  logic [NW-1:0]   clr_n;
  logic [31:0]     rd_sum, cw_sum;
  logic [5:0]      rd_j_inc;

  assign tick      = (slot_ticks == 5'd0) ? 5'd1 : slot_ticks;
  assign rd_price  = mem_rdata[WW-1 -: PB];
  assign rd_size   = mem_rdata[IDXW +: 32];
  assign rd_next   = mem_rdata[IDXW-1:0];
  assign cfg_ready = !busy;
  assign busy      = (state != ST_IDLE);

  assign cmd_ok = (c_mode == MODE_NEW || c_mode == MODE_CHANGE || c_mode == MODE_REMOVE)
                  && (c_price != '0);
  assign bp       = best_price[c_side];
  assign dist_hi  = c_side ? bp : c_price;
  assign dist_lo  = c_side ? c_price : bp;
  assign neg_comb = dist_hi < dist_lo;
  assign m_comb   = neg_comb ? dist_lo - dist_hi : dist_hi - dist_lo;

  // A negative distance rounds up in magnitude.
  assign off_comb  = neg ? div_quo + PB'(div_rem != '0) : div_quo;
  assign off_big   = CMPW'(off_comb) >= CMPW'(S);
  assign rebase_go = !rebased && (c_mode == MODE_NEW) && neg;
  assign clr_n     = off_big ? NW'(S) : NW'(off_comb);
  assign ring_sum  = (SW+1)'(best_slot[c_side]) + (SW+1)'(SW'(off_comb));
  assign ring_comb = (ring_sum >= (SW+1)'(S)) ? SW'(ring_sum - (SW+1)'(S)) : SW'(ring_sum);
  // A move of a full ring or more empties every slot, so the new best slot only keeps its
  // exact position where the ring size is a power of two.
  assign offmod    = (S_POW2 || CMPW'(off) < CMPW'(S)) ? SW'(off) : '0;
  assign nb_sum    = (SW+1)'(best_slot[c_side]) + (SW+1)'(S) - (SW+1)'(offmod);
  assign nb_slot   = (best_slot[c_side] >= offmod) ? best_slot[c_side] - offmod : SW'(nb_sum);
  assign step_comb = (tick_rem == '0) ? mag : mag - PB'(tick_rem) + PB'(tick);
  assign rd_sum    = rd_size + c_delta;
  assign cw_sum    = cw_size + c_delta;
  assign rd_j_inc  = {1'b0, rd_j} + 6'd1;

  assign give_to_bump = ((IDXW+1)'(give_idx) + 1'b1) == (IDXW+1)'(bump);
  assign hole_push    = give_en && !give_to_bump && (hole_count < HCW'(C));
  assign tail_sum     = (HCW+1)'(hole_head) + (HCW+1)'(hole_count);
  assign hole_tail    = (tail_sum >= (HCW+1)'(C)) ? HW'(tail_sum - (HCW+1)'(C)) : HW'(tail_sum);
  assign hole_inc     = (hole_head == HW'(C - 1)) ? '0 : hole_head + 1'b1;

  plob_ram #(.WIDTH(WW), .DEPTH(TOTAL)) u_blocks (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr[AW-1:0]),
    .rdata (mem_rdata)
  );

  plob_ram #(.WIDTH(IDXW), .DEPTH(C)) u_holes (
    .clk   (clk),
    .we    (hole_push),
    .waddr (hole_tail),
    .wdata (give_idx),
    .raddr (hole_head),
    .rdata (hole_rdata)
  );

  plob_div #(.DW(PB), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;
    give_en    = 1'b0;
    give_idx   = '0;
    div_start  = 1'b0;
    div_a      = m_comb;
    div_b      = VW'(tick);
    emit       = 1'b0;
    emit_word  = '0;
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt;
        mem_wdata = pack('0, '0, NIL);
        if (init_cnt == IDXW'(2 * S - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = cmd_ok ? ST_DIST_GO : ST_DONE;
      end
      ST_DIST_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIST_WAIT;
      end
      ST_DIST_WAIT: begin
        if (div_done) begin
          if (rebase_go) begin
            state_next = ST_REBASE;
          end else if (off_big) begin
            state_next = ST_DONE;
          end else if (c_mode == MODE_NEW) begin
            state_next = ST_N_HEAD_RQ;
          end else begin
            state_next = ST_C_WALK;
          end
        end
      end
      ST_REBASE: begin
        state_next = ST_CLR;
      end
      ST_CLR: begin
        mem_raddr = head_of(c_side, clr_slot);
        if (clr_left == '0) begin
          state_next = ST_DIST_GO;
        end else begin
          state_next = ST_CLR_CHK;
        end
      end
      ST_CLR_CHK: begin
        if (rd_price != '0) begin
          mem_we     = 1'b1;
          mem_waddr  = head_of(c_side, clr_slot);
          mem_wdata  = pack('0, rd_size, rd_next);
          state_next = ST_FREE;
        end else begin
          state_next = ST_CLR;
        end
      end
      ST_FREE: begin
        mem_raddr = link;
        if (link >= NIL) begin
          state_next = ST_CLR;
        end else begin
          state_next = ST_FREE_RD;
        end
      end
      ST_FREE_RD: begin
        give_en    = 1'b1;
        give_idx   = link;
        state_next = ST_FREE;
      end
      ST_N_HEAD_RQ: begin
        mem_raddr  = head;
        state_next = ST_N_HEAD;
      end
      ST_N_HEAD: begin
        if (rd_price == '0) begin
          mem_we     = 1'b1;
          mem_waddr  = head;
          mem_wdata  = pack(c_price, c_delta, NIL);
          state_next = ST_DONE;
        end else if (rd_price == c_price) begin
          mem_we     = 1'b1;
          mem_waddr  = head;
          mem_wdata  = pack(rd_price, rd_sum, rd_next);
          state_next = ST_DONE;
        end else if (!worse(c_price, rd_price, c_side)) begin
          state_next = ST_TAKE;
        end else begin
          state_next = ST_N_WALK;
        end
      end
      ST_N_WALK: begin
        mem_raddr = cur;
        if (walk_i >= tick) begin
          state_next = ST_DONE;
        end else if (cur >= NIL) begin
          state_next = ST_TAKE;
        end else begin
          state_next = ST_N_WALK_RD;
        end
      end
      ST_N_WALK_RD: begin
        if (worse(rd_price, c_price, c_side)) begin
          state_next = ST_TAKE;
        end else if (rd_price == c_price) begin
          mem_we     = 1'b1;
          mem_waddr  = cur;
          mem_wdata  = pack(rd_price, rd_sum, rd_next);
          state_next = ST_DONE;
        end else begin
          state_next = ST_N_WALK;
        end
      end
      ST_TAKE: begin
        if (hole_count != '0) begin
          state_next = ST_TAKE_RD;
        end else if (bump < NIL) begin
          state_next = ST_PLACE_A;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_TAKE_RD: begin
        state_next = ST_PLACE_A;
      end
      ST_PLACE_A: begin
        mem_we = 1'b1;
        if (front) begin
          mem_waddr = nb;
          mem_wdata = pack(lw_price, lw_size, lw_next);
        end else begin
          mem_waddr = last;
          mem_wdata = pack(lw_price, lw_size, nb);
        end
        state_next = ST_PLACE_B;
      end
      ST_PLACE_B: begin
        mem_we = 1'b1;
        if (front) begin
          mem_waddr = head;
          mem_wdata = pack(c_price, c_delta, nb);
        end else begin
          mem_waddr = nb;
          mem_wdata = pack(c_price, c_delta, (cur >= NIL) ? NIL : cur);
        end
        state_next = ST_DONE;
      end
      ST_C_WALK: begin
        mem_raddr = cur;
        if (walk_i >= tick || cur >= NIL) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_C_RD;
        end
      end
      ST_C_RD: begin
        if (walk_i == '0 && rd_price == '0) begin
          state_next = ST_DONE;
        end else if (rd_price == c_price) begin
          state_next = ST_C_FOUND;
        end else begin
          state_next = ST_C_WALK;
        end
      end
      ST_C_FOUND: begin
        mem_raddr = cw_next;
        if (c_mode == MODE_CHANGE && cw_sum != '0 && !cw_sum[31]) begin
          mem_we     = 1'b1;
          mem_waddr  = cur;
          mem_wdata  = pack(c_price, cw_sum, cw_next);
          state_next = ST_DONE;
        end else if (cur == head) begin
          if (cw_next >= NIL) begin
            mem_we     = 1'b1;
            mem_waddr  = head;
            mem_wdata  = pack('0, cw_size, cw_next);
            state_next = (ring == best_slot[c_side]) ? ST_RS : ST_DONE;
          end else begin
            // The next block moves up into the slot head.
            give_en    = 1'b1;
            give_idx   = cw_next;
            state_next = ST_C_PULL;
          end
        end else begin
          give_en    = 1'b1;
          give_idx   = cur;
          mem_we     = 1'b1;
          mem_waddr  = last;
          mem_wdata  = pack(lw_price, lw_size, cw_next);
          state_next = ST_DONE;
        end
      end
      ST_C_PULL: begin
        mem_we     = 1'b1;
        mem_waddr  = head;
        mem_wdata  = mem_rdata;
        state_next = ST_DONE;
      end
      ST_RS: begin
        mem_raddr = head_of(c_side, rs_slot);
        if (rs_k >= NW'(S)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RS_RD;
        end
      end
      ST_RS_RD: begin
        state_next = (rd_price != '0) ? ST_DONE : ST_RS;
      end
      ST_DONE: begin
        state_next = c_rr ? ST_RD_SIDE : ST_IDLE;
      end
      ST_RD_SIDE: begin
        state_next = ST_RD_SLOT;
      end
      ST_RD_SLOT: begin
        mem_raddr = head_of(rd_side, rd_slot);
        if (rd_i < NW'(S) && rd_cnt != '0) begin
          state_next = ST_RD_DATA;
        end else begin
          state_next = ST_RD_MARK;
        end
      end
      ST_RD_DATA: begin
        mem_raddr = rd_next;
        if (rd_at_head && rd_price == '0) begin
          state_next = ST_RD_SLOT;
        end else begin
          emit                  = 1'b1;
          emit_word.level_price = 32'(rd_price);
          emit_word.level_size  = rd_size;
          if (rd_next < NIL && rd_cnt != 5'd1 && rd_j_inc < {1'b0, tick}) begin
            state_next = ST_RD_DATA;
          end else begin
            state_next = ST_RD_SLOT;
          end
        end
      end
      ST_RD_MARK: begin
        emit                  = 1'b1;
        emit_word.level_price = '0;
        emit_word.level_size  = MARK_SIZE;
        emit_word.end_of_side = 1'b1;
        emit_word.last        = rd_side;
        state_next            = rd_side ? ST_IDLE : ST_RD_SIDE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt      <= '0;
      slot_ticks    <= RESET_TICKS;
      read_limit    <= RESET_TICKS;
      best_price[0] <= '0;
      best_price[1] <= '0;
      best_slot[0]  <= '0;
      best_slot[1]  <= '0;
      hole_head     <= '0;
      hole_count    <= '0;
      bump          <= IDXW'(2 * S);
      result_valid  <= 1'b0;
    end else begin
      result_valid <= emit;
      result       <= emit_word;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLOT_TICKS: slot_ticks <= cfg_data;
          REG_READ_LIMIT: read_limit <= cfg_data;
          default: ;
        endcase
      end
      if (give_en) begin
        if (give_to_bump) begin
          bump <= bump - 1'b1;
        end else if (hole_push) begin
          hole_count <= hole_count + 1'b1;
        end
      end
      case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + 1'b1;
        end
        ST_IDLE: begin
          if (start) begin
            c_mode  <= cmd.mode;
            c_side  <= cmd.side;
            c_price <= PB'(cmd.price);
            c_delta <= cmd.size_delta;
            c_rr    <= cmd.read_request;
          end
        end
        ST_CHECK: begin
          rebased <= 1'b0;
          if (cmd_ok && bp == '0) begin
            best_price[c_side] <= c_price;
          end
        end
        ST_DIST_GO: begin
          neg <= neg_comb;
          mag <= m_comb;
        end
        ST_DIST_WAIT: begin
          if (div_done) begin
            off      <= off_comb;
            tick_rem <= div_rem;
            clr_left <= clr_n;
            ring     <= ring_comb;
            head     <= head_of(c_side, ring_comb);
            cur      <= head_of(c_side, ring_comb);
            walk_i   <= '0;
          end
        end
        ST_REBASE: begin
          best_slot[c_side]  <= nb_slot;
          clr_slot           <= nb_slot;
          best_price[c_side] <= c_side ? bp + step_comb : bp - step_comb;
        end
        ST_CLR: begin
          if (clr_left == '0) begin
            rebased <= 1'b1;
          end
        end
        ST_CLR_CHK: begin
          clr_left <= clr_left - 1'b1;
          clr_slot <= slot_inc(clr_slot);
          link     <= rd_next;
        end
        ST_FREE_RD: begin
          link <= rd_next;
        end
        ST_N_HEAD: begin
          front    <= !worse(c_price, rd_price, c_side);
          last     <= head;
          lw_price <= rd_price;
          lw_size  <= rd_size;
          lw_next  <= rd_next;
          cur      <= rd_next;
        end
        ST_N_WALK_RD: begin
          // A worse block stays as the successor of the new one.
          if (!worse(rd_price, c_price, c_side)) begin
            last     <= cur;
            lw_price <= rd_price;
            lw_size  <= rd_size;
            lw_next  <= rd_next;
            cur      <= rd_next;
            walk_i   <= walk_i + 1'b1;
          end
        end
        ST_TAKE: begin
          if (hole_count != '0) begin
            hole_head  <= hole_inc;
            hole_count <= hole_count - 1'b1;
          end else if (bump < NIL) begin
            nb   <= bump;
            bump <= bump + 1'b1;
          end
        end
        ST_TAKE_RD: begin
          nb <= hole_rdata;
        end
        ST_C_RD: begin
          cw_size  <= rd_size;
          cw_next  <= rd_next;
          if (rd_price != c_price) begin
            last     <= cur;
            lw_price <= rd_price;
            lw_size  <= rd_size;
            cur      <= rd_next;
            walk_i   <= walk_i + 1'b1;
          end
        end
        ST_C_FOUND: begin
          rs_k    <= NW'(1);
          rs_slot <= slot_inc(best_slot[c_side]);
          rs_step <= PB'(tick);
        end
        ST_RS_RD: begin
          if (rd_price != '0) begin
            best_slot[c_side]  <= rs_slot;
            best_price[c_side] <= c_side ? bp - rs_step : bp + rs_step;
          end else begin
            rs_k    <= rs_k + 1'b1;
            rs_slot <= slot_inc(rs_slot);
            rs_step <= rs_step + PB'(tick);
          end
        end
        ST_DONE: begin
          rd_side <= 1'b0;
        end
        ST_RD_SIDE: begin
          rd_cnt  <= read_limit;
          rd_i    <= '0;
          rd_slot <= best_slot[rd_side];
        end
        ST_RD_SLOT: begin
          rd_j       <= '0;
          rd_at_head <= 1'b1;
        end
        ST_RD_DATA: begin
          if (rd_at_head && rd_price == '0) begin
            rd_i    <= rd_i + 1'b1;
            rd_slot <= slot_inc(rd_slot);
          end else begin
            rd_cnt     <= rd_cnt - 1'b1;
            rd_at_head <= 1'b0;
            if (rd_next < NIL && rd_cnt != 5'd1 && rd_j_inc < {1'b0, tick}) begin
              rd_j <= rd_j + 1'b1;
            end else begin
              rd_i    <= rd_i + 1'b1;
              rd_slot <= slot_inc(rd_slot);
            end
          end
        end
        ST_RD_MARK: begin
          rd_side <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> (!busy && result.end_of_side))
    else $error("final word of a snapshot while still busy");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIST_WAIT))
    else $error("divider finished outside a wait state");

  a_holes_bound: assert property (@(posedge clk) disable iff (rst)
    hole_push |-> (hole_count < HCW'(C)))
    else $error("hole queue overfilled");
`endif

endmodule
